>>> src/rrw_pkg.sv
// Shared types and constants for the receive ring walker.
// Used by every module of the block; depends on nothing.
package rrw_pkg;

    localparam int PAGE_BITS    = 8;
    localparam int HEADER_BYTES = 4;
    localparam int LEN_BITS     = 16;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [LEN_BITS-1:0]  len_t;

    // Command carried by an input item
    typedef enum logic {
        CMD_BEGIN  = 1'b0,
        CMD_HEADER = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DELIVER    = 3'd0,
        ST_SKIPPED    = 3'd1,
        ST_CORRUPT    = 3'd2,
        ST_STEP_LIMIT = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_WALK_START = 3'd5,
        ST_NO_WALK    = 3'd6
    } status_t;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RING_START = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RING_STOP  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_LENGTH = 2'd2;

    localparam page_t RESET_RING_START = 8'd12;
    localparam page_t RESET_RING_STOP  = 8'd64;
    localparam len_t  RESET_MAX_LENGTH = 16'd1536;

    typedef struct packed {
        page_t ring_start_page;
        page_t ring_stop_page;
        len_t  max_length;
    } cfg_t;

    typedef struct packed {
        page_t next_page;
        page_t walk_target;
        page_t steps_left;
        logic  walk_active;
    } state_t;

    typedef struct packed {
        cmd_t  command;
        page_t current_page;
        page_t header_next;
        len_t  header_count;
    } item_t;

    typedef struct packed {
        len_t    frame_length;
        page_t   header_page;
        status_t status;
        page_t   boundary;
        logic    walk_done;
    } result_t;

endpackage

>>> src/receive_ring_walk.sv
// Top level of the receive ring walker: item register, step logic, result register.
// Depends on rrw_pkg, rrw_cfg and rrw_step.
//
// The block walks a page-based receive ring one packet header at a time. A begin
// item (tuser 0) carries the chip's current write page: if it equals the ring
// pointer the ring is empty, otherwise a walk starts with a step limit of the
// ring's page count. Each header item (tuser 1) rebuilds the packet length from
// the distance to the next-packet page, wrapping round the ring, and trusts only
// the low byte of the header's byte count. A corrupt next pointer, or an
// exhausted step limit, puts the pointer back to one past the ring start. The
// result gives the frame length (zero unless delivered), the page where the
// header lay, a status code on m_tuser, and the boundary page to write back;
// m_tlast marks the item that ends the walk or found nothing to do.
// One item is taken every clock cycle while the master side does not stall;
// each result passes through the item register and then the result register.
// The rate is set by the pointer state loop, which the combinational step logic
// closes. A stalled master side holds the result and, once the item register is
// also full, deasserts s_tready. Configuration registers are to be written through
// cfg_wen/cfg_addr/cfg_data only while the block is idle, which it does not enforce.
module receive_ring_walk (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wen,
    input  logic [rrw_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [rrw_pkg::LEN_BITS-1:0]        cfg_data,
    // item input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // current_page, header_next, header_count
    input  logic                                s_tuser,  // command
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // frame_length, header_page, boundary
    output logic [2:0]                          m_tuser,  // status
    output logic                                m_tlast   // walk_done
);
    import rrw_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    rrw_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    rrw_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Advance the held item into the result register when that register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Item register: valid cleared by reset, payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.command      <= cmd_t'(s_tuser);
            item_reg.current_page <= s_tdata[7:0];
            item_reg.header_next  <= s_tdata[15:8];
            item_reg.header_count <= s_tdata[31:16];
        end
    end

    // Ring pointer state: update only as an item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.next_page   <= RESET_RING_START + 8'd1;
            state_reg.walk_target <= '0;
            state_reg.steps_left  <= '0;
            state_reg.walk_active <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while the master side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.boundary, out_reg.header_page, out_reg.frame_length};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.walk_done;

endmodule

>>> src/rrw_cfg.sv
// Configuration register file of the receive ring walker.
// Depends on rrw_pkg.
module rrw_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [rrw_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [rrw_pkg::LEN_BITS-1:0]         cfg_data,
    output rrw_pkg::cfg_t                        cfg
);
    import rrw_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_start_page <= RESET_RING_START;
            cfg_reg.ring_stop_page  <= RESET_RING_STOP;
            cfg_reg.max_length      <= RESET_MAX_LENGTH;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_RING_START: cfg_reg.ring_start_page <= cfg_data[PAGE_BITS-1:0];
                REG_RING_STOP:  cfg_reg.ring_stop_page  <= cfg_data[PAGE_BITS-1:0];
                REG_MAX_LENGTH: cfg_reg.max_length      <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/rrw_step.sv
// Single-item step of the ring walk: next pointer state and one result.
// Purely combinational; depends on rrw_pkg.
module rrw_step (
    input  rrw_pkg::cfg_t    cfg,
    input  rrw_pkg::state_t  state,
    input  rrw_pkg::item_t   item,
    output rrw_pkg::state_t  state_next,
    output rrw_pkg::result_t result
);
    import rrw_pkg::*;

    page_t start_p;
    page_t stop_p;
    page_t np;
    page_t hn;
    page_t low;
    page_t idle_bnd;
    page_t new_bnd;
    page_t span;
    page_t nlen;
    len_t  len;
    page_t steps_dec;
    logic  corrupt;
    logic  len_ok;

    assign start_p = cfg.ring_start_page;
    assign stop_p  = cfg.ring_stop_page;
    assign np      = state.next_page;
    assign hn      = item.header_next;
    assign low     = item.header_count[PAGE_BITS-1:0];

    // Page before the pointer, wrapped to the ring's last page
    assign idle_bnd = ((np - 8'd1) < start_p) ? (stop_p - 8'd1) : (np - 8'd1);
    assign new_bnd  = ((hn - 8'd1) < start_p) ? (stop_p - 8'd1) : (hn - 8'd1);

    // Rebuild the length from the next-page distance
    assign span = (hn >= np) ? (hn - np) : ((hn - start_p) + (stop_p - np));
    assign nlen = span - ((low > 8'(256 - HEADER_BYTES)) ? 8'd2 : 8'd1);
    assign len  = {nlen, low};

    assign corrupt   = (hn < start_p) || (hn >= stop_p) || (hn == np);
    assign len_ok    = (len > LEN_BITS'(HEADER_BYTES)) && (len <= cfg.max_length);
    assign steps_dec = state.steps_left - 8'd1;

    always_comb
    begin
        state_next          = state;
        result.frame_length = '0;
        result.header_page  = np;
        result.status       = ST_NO_WALK;
        result.boundary     = idle_bnd;
        result.walk_done    = 1'b0;
        case (item.command)
            CMD_BEGIN:
            begin
                if (np == item.current_page)
                begin
                    state_next.walk_active = 1'b0;
                    result.status          = ST_EMPTY;
                    result.walk_done       = 1'b1;
                end
                else
                begin
                    state_next.walk_target = item.current_page;
                    state_next.steps_left  = stop_p - start_p;
                    state_next.walk_active = 1'b1;
                    result.status          = ST_WALK_START;
                end
            end
            CMD_HEADER:
            begin
                if (!state.walk_active)
                begin
                    result.status    = ST_NO_WALK;
                    result.walk_done = 1'b1;
                end
                else if (corrupt)
                begin
                    state_next.next_page   = start_p + 8'd1;
                    state_next.walk_active = 1'b0;
                    result.boundary        = start_p;
                    result.status          = ST_CORRUPT;
                    result.walk_done       = 1'b1;
                end
                else
                begin
                    if (len_ok)
                    begin
                        result.frame_length = len - LEN_BITS'(HEADER_BYTES);
                        result.status       = ST_DELIVER;
                    end
                    else
                    begin
                        result.status = ST_SKIPPED;
                    end
                    state_next.next_page  = hn;
                    state_next.steps_left = steps_dec;
                    result.boundary       = new_bnd;
                    if (steps_dec == 8'd0)
                    begin
                        state_next.next_page   = start_p + 8'd1;
                        state_next.walk_active = 1'b0;
                        result.boundary        = start_p;
                        result.status          = ST_STEP_LIMIT;
                        result.walk_done       = 1'b1;
                    end
                    else if (hn == state.walk_target)
                    begin
                        state_next.walk_active = 1'b0;
                        result.walk_done       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/rrw_checker.sv
// Port-level checks on the receive ring walker's result channel, and their binding.
// Depends on rrw_pkg and receive_ring_walk.
module rrw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import rrw_pkg::*;

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Every ending or idle status closes the walk
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_CORRUPT || m_tuser == ST_STEP_LIMIT ||
                     m_tuser == ST_EMPTY || m_tuser == ST_NO_WALK) |-> m_tlast)
        else $error("walk end missing on terminal status");

    // A walk that just started is never over
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_WALK_START |-> !m_tlast)
        else $error("walk start marked as last");

    // Only a delivery (or a step limit hit on a delivery) carries a length
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SKIPPED || m_tuser == ST_CORRUPT ||
                     m_tuser == ST_EMPTY || m_tuser == ST_WALK_START ||
                     m_tuser == ST_NO_WALK) |-> m_tdata[15:0] == 16'd0)
        else $error("frame length set without delivery");

endmodule

bind receive_ring_walk rrw_checker u_rrw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
